>>> rtl/core/aapc_pkg.sv
// ----------------------------------------------------------------------------
// aapc_pkg
// Shared types, constants and helpers for the all-pairs box collision block.
// ----------------------------------------------------------------------------
package aapc_pkg;

  // Default capacity of the box store
  localparam int unsigned MaxEntitiesDef = 8;

  localparam int unsigned IdW    = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned EdgeW  = CoordW + 2;
  localparam int unsigned BoxW   = 4 * CoordW;

  // One input transaction: a box to load
  typedef struct packed {
    logic [IdW-1:0]           entity_id;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic [CoordW-1:0]        box_width;
    logic [CoordW-1:0]        box_height;
    logic                     final_box;
  } item_t;

  // One result transaction: a colliding pair or the end marker
  typedef struct packed {
    logic [IdW-1:0]    first_id;
    logic [IdW-1:0]    second_id;
    logic [CoordW-1:0] overlap_x;
    logic [CoordW-1:0] overlap_y;
    logic              is_pair;
    logic              overflowed;
    logic              end_of_run;
  } result_t;

  // Edges of one box, exact in 18 signed bits
  typedef struct packed {
    logic signed [EdgeW-1:0] left;
    logic signed [EdgeW-1:0] right;
    logic signed [EdgeW-1:0] top;
    logic signed [EdgeW-1:0] bottom;
  } edges_t;

  // Unpack a stored box (x, y, w, h from the low end) into its edges
  function automatic edges_t box_edges(logic [BoxW-1:0] box);
    edges_t e;
    e.left   = EdgeW'(signed'(box[CoordW-1:0]));
    e.top    = EdgeW'(signed'(box[2*CoordW-1:CoordW]));
    e.right  = e.left + signed'({2'b00, box[3*CoordW-1:2*CoordW]});
    e.bottom = e.top + signed'({2'b00, box[4*CoordW-1:3*CoordW]});
    return e;
  endfunction

endpackage

>>> rtl/core/aabb_all_pairs_collision.sv
// ----------------------------------------------------------------------------
// aabb_all_pairs_collision
// Brute-force collision detection over a set of axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present a box on item_i and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. Each box is written
//   into the id and box RAMs; boxes beyond MaxEntities are
//   dropped and remembered for the end marker.
//   A box with final_box set starts the pair sweep, during which busy is high.
//   Every pair i<j is tested in load order; each strict overlap produces one
//   result transaction, and one end marker (end_of_run, overflowed) closes
//   the run, after which the store is emptied.
//   Output: each result on result_o is marked by result_valid_o, high for
//   exactly one cycle. The receiver cannot stall, so none is ever held back.
//   Timing: a new box can be taken every clock while busy is low. In the
//   sweep over the stored boxes each pair costs a RAM read and a test,
//   and each row one extra read to fetch its first box; the single read
//   port of the box RAM sets this cost.
//   Reset: clears the box count, the drop flag and the sequencer; RAM
//   contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module aabb_all_pairs_collision #(
  parameter int unsigned MaxEntities = aapc_pkg::MaxEntitiesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  aapc_pkg::item_t   item_i,
  output logic              result_valid_o,
  output aapc_pkg::result_t result_o
);

  localparam int unsigned IdxW = (MaxEntities > 1) ? $clog2(MaxEntities) : 1;
  localparam int unsigned CntW = $clog2(MaxEntities + 1);

  // Sweep sequencer, one-hot
  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StRdI  = 6'b000010,
    StLatI = 6'b000100,
    StLatJ = 6'b001000,
    StTest = 6'b010000,
    StEnd  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;

  logic                      res_valid_q, res_valid_d;
  aapc_pkg::result_t         res_q, res_d;

  // Row box (earlier) and column box (later) of the pair under test
  aapc_pkg::edges_t          a_q, b_q;
  logic [aapc_pkg::IdW-1:0]  aid_q, bid_q;

  logic                      accept;
  logic                      we;
  logic [IdxW-1:0]           raddr;
  logic [aapc_pkg::IdW-1:0]  id_rdata;
  logic [aapc_pkg::BoxW-1:0] box_rdata, box_wdata;

  logic                         hit;
  logic [aapc_pkg::CoordW-1:0]  ov_x, ov_y;

  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);

  assign box_wdata = {item_i.box_height, item_i.box_width,
                      item_i.pos_y, item_i.pos_x};

  aapc_ram #(
    .Width (aapc_pkg::IdW),
    .Depth (MaxEntities)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (item_i.entity_id),
    .raddr_i (raddr),
    .rdata_o (id_rdata)
  );

  aapc_ram #(
    .Width (aapc_pkg::BoxW),
    .Depth (MaxEntities)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (box_wdata),
    .raddr_i (raddr),
    .rdata_o (box_rdata)
  );

  aapc_pair_test u_pair_test (
    .a_i         (a_q),
    .b_i         (b_q),
    .hit_o       (hit),
    .overlap_x_o (ov_x),
    .overlap_y_o (ov_y)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    we          = 1'b0;
    raddr       = '0;
    res_valid_d = 1'b0;
    res_d       = res_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          // Store the box while there is room, otherwise drop and flag it
          if (count_q < CntW'(MaxEntities)) begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (item_i.final_box) begin
            i_d     = '0;
            state_d = StRdI;
          end
        end
      end
      StRdI: begin
        // Advance to the end marker once no later box is left for row i
        if ((CntW'(i_q) + CntW'(1)) >= count_q) begin
          state_d = StEnd;
        end else begin
          raddr   = i_q;
          state_d = StLatI;
        end
      end
      StLatI: begin
        j_d     = i_q + IdxW'(1);
        raddr   = i_q + IdxW'(1);
        state_d = StLatJ;
      end
      StLatJ: begin
        state_d = StTest;
      end
      StTest: begin
        if (hit) begin
          res_valid_d      = 1'b1;
          res_d.first_id   = aid_q;
          res_d.second_id  = bid_q;
          res_d.overlap_x  = ov_x;
          res_d.overlap_y  = ov_y;
          res_d.is_pair    = 1'b1;
          res_d.overflowed = 1'b0;
          res_d.end_of_run = 1'b0;
        end
        // Fetch the next column while the row box is held
        if ((CntW'(j_q) + CntW'(1)) < count_q) begin
          j_d     = j_q + IdxW'(1);
          raddr   = j_q + IdxW'(1);
          state_d = StLatJ;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = StRdI;
        end
      end
      StEnd: begin
        res_valid_d      = 1'b1;
        res_d.first_id   = '0;
        res_d.second_id  = '0;
        res_d.overlap_x  = '0;
        res_d.overlap_y  = '0;
        res_d.is_pair    = 1'b0;
        res_d.overflowed = drop_q;
        res_d.end_of_run = 1'b1;
        count_d          = '0;
        drop_d           = 1'b0;
        state_d          = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      i_q         <= i_d;
      j_q         <= j_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers: hold the row and column boxes and the result
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == StLatI) begin
      a_q   <= aapc_pkg::box_edges(box_rdata);
      aid_q <= id_rdata;
    end
    if (state_q == StLatJ) begin
      b_q   <= aapc_pkg::box_edges(box_rdata);
      bid_q <= id_rdata;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

>>> rtl/core/aapc_ram.sv
// ----------------------------------------------------------------------------
// aapc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module aapc_ram #(
  parameter int unsigned Width = aapc_pkg::BoxW,
  parameter int unsigned Depth = aapc_pkg::MaxEntitiesDef,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/aapc_pair_test.sv
// ----------------------------------------------------------------------------
// aapc_pair_test
// Strict-overlap test of two boxes and their intersection lengths.
// ----------------------------------------------------------------------------
module aapc_pair_test (
  input  aapc_pkg::edges_t              a_i,
  input  aapc_pkg::edges_t              b_i,
  output logic                          hit_o,
  output logic [aapc_pkg::CoordW-1:0]   overlap_x_o,
  output logic [aapc_pkg::CoordW-1:0]   overlap_y_o
);

  logic signed [aapc_pkg::EdgeW-1:0] min_r, max_l, min_b, max_t;
  logic signed [aapc_pkg::EdgeW-1:0] ox, oy;

  // Touching edges do not count: all four comparisons are strict
  assign hit_o = (a_i.left < b_i.right) && (a_i.right > b_i.left) &&
                 (a_i.top < b_i.bottom) && (a_i.bottom > b_i.top);

  assign min_r = (a_i.right < b_i.right)   ? a_i.right  : b_i.right;
  assign max_l = (a_i.left > b_i.left)     ? a_i.left   : b_i.left;
  assign min_b = (a_i.bottom < b_i.bottom) ? a_i.bottom : b_i.bottom;
  assign max_t = (a_i.top > b_i.top)       ? a_i.top    : b_i.top;

  assign ox = min_r - max_l;
  assign oy = min_b - max_t;

  // An overlap never exceeds the smaller size, so the low bits carry it
  assign overlap_x_o = ox[aapc_pkg::CoordW-1:0];
  assign overlap_y_o = oy[aapc_pkg::CoordW-1:0];

endmodule
